/* src/mkd_pkg.sv */
package mkd_pkg;

    localparam int MKD_MAX_ELEMENTS = 5;
    localparam int MKD_CNT_W        = $clog2(MKD_MAX_ELEMENTS + 1);
    localparam int MKD_TICK_W       = 16;
    localparam int MKD_QDEPTH       = 4;
    localparam int MKD_QPTR_W       = $clog2(MKD_QDEPTH);

    localparam logic [MKD_TICK_W-1:0] MKD_DASH_TICKS_RST = 16'd750;
    localparam logic [MKD_TICK_W-1:0] MKD_PRESS_SAT      = '1;

    localparam logic [1:0] EV_DOT     = 2'd0;
    localparam logic [1:0] EV_DASH    = 2'd1;
    localparam logic [1:0] EV_CHAR    = 2'd2;
    localparam logic [1:0] EV_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0] event_res;
        logic [6:0] char_code;
        logic [2:0] symbol_length;
        logic       last;
    } mkd_res_t;

    // one accepted request gives one or two results
    typedef struct packed {
        logic     two;
        mkd_res_t r0;
        mkd_res_t r1;
    } mkd_rec_t;

    // bit i of bits is element i, 1 = dash; returns 0 when no letter matches
    function automatic logic [6:0] mkd_lookup(input logic [MKD_CNT_W-1:0]        cnt,
                                              input logic [MKD_MAX_ELEMENTS-1:0] bits);
        logic [6:0] ch;
        ch = 7'd0;
        case (cnt)
            MKD_CNT_W'(1):
            begin
                if (bits == MKD_MAX_ELEMENTS'(0)) ch = 7'd69;       // E
                else if (bits == MKD_MAX_ELEMENTS'(1)) ch = 7'd84;  // T
            end
            MKD_CNT_W'(2):
            begin
                case (bits)
                    MKD_MAX_ELEMENTS'(0): ch = 7'd73;  // I
                    MKD_MAX_ELEMENTS'(1): ch = 7'd78;  // N
                    MKD_MAX_ELEMENTS'(2): ch = 7'd65;  // A
                    MKD_MAX_ELEMENTS'(3): ch = 7'd77;  // M
                    default: ch = 7'd0;
                endcase
            end
            MKD_CNT_W'(3):
            begin
                case (bits)
                    MKD_MAX_ELEMENTS'(0): ch = 7'd83;  // S
                    MKD_MAX_ELEMENTS'(1): ch = 7'd68;  // D
                    MKD_MAX_ELEMENTS'(2): ch = 7'd82;  // R
                    MKD_MAX_ELEMENTS'(3): ch = 7'd71;  // G
                    MKD_MAX_ELEMENTS'(4): ch = 7'd85;  // U
                    MKD_MAX_ELEMENTS'(5): ch = 7'd75;  // K
                    MKD_MAX_ELEMENTS'(6): ch = 7'd87;  // W
                    MKD_MAX_ELEMENTS'(7): ch = 7'd79;  // O
                    default: ch = 7'd0;
                endcase
            end
            MKD_CNT_W'(4):
            begin
                case (bits)
                    MKD_MAX_ELEMENTS'(0):  ch = 7'd72;  // H
                    MKD_MAX_ELEMENTS'(1):  ch = 7'd66;  // B
                    MKD_MAX_ELEMENTS'(2):  ch = 7'd76;  // L
                    MKD_MAX_ELEMENTS'(3):  ch = 7'd90;  // Z
                    MKD_MAX_ELEMENTS'(4):  ch = 7'd70;  // F
                    MKD_MAX_ELEMENTS'(5):  ch = 7'd67;  // C
                    MKD_MAX_ELEMENTS'(6):  ch = 7'd80;  // P
                    MKD_MAX_ELEMENTS'(8):  ch = 7'd86;  // V
                    MKD_MAX_ELEMENTS'(9):  ch = 7'd88;  // X
                    MKD_MAX_ELEMENTS'(11): ch = 7'd81;  // Q
                    MKD_MAX_ELEMENTS'(13): ch = 7'd89;  // Y
                    MKD_MAX_ELEMENTS'(14): ch = 7'd74;  // J
                    default: ch = 7'd0;
                endcase
            end
            MKD_CNT_W'(5):
            begin
                // five dashes give a space
                if (bits == MKD_MAX_ELEMENTS'(31)) ch = 7'd32;
            end
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage

/* src/mkd_front.sv */
module mkd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           key_level,
    input  logic                           clear_press,
    input  logic                           confirm_press,
    input  logic                           cfg_we,
    input  logic [mkd_pkg::MKD_TICK_W-1:0] cfg_wdata,
    output logic                           q_push,
    output mkd_pkg::mkd_rec_t              q_rec
);
    import mkd_pkg::*;

    logic [MKD_TICK_W-1:0]       dash_ticks_reg;
    logic                        key_held_reg, key_held_next;
    logic [MKD_TICK_W-1:0]       press_count_reg, press_count_next;
    logic [MKD_MAX_ELEMENTS-1:0] element_bits_reg, element_bits_next;
    logic [MKD_CNT_W-1:0]        element_count_reg, element_count_next;
    logic                        overflowed_reg, overflowed_next;

    logic                        release_hit;
    logic                        dash;
    logic [MKD_MAX_ELEMENTS-1:0] bits_rel;
    logic [MKD_CNT_W-1:0]        cnt_rel;
    logic                        ovf_rel;
    logic [6:0]                  ch;
    mkd_res_t                    rel_res, conf_res;

    always_comb
    begin
        release_hit = !key_level && key_held_reg;
        dash        = press_count_reg > dash_ticks_reg;

        key_held_next    = key_held_reg;
        press_count_next = press_count_reg;
        if (key_level)
        begin
            key_held_next = 1'b1;
            if (!key_held_reg)
                press_count_next = MKD_TICK_W'(1);
            else if (press_count_reg != MKD_PRESS_SAT)
                press_count_next = press_count_reg + MKD_TICK_W'(1);
        end
        else if (key_held_reg)
        begin
            key_held_next    = 1'b0;
            press_count_next = '0;
        end

        // string after the release element, if any
        bits_rel = element_bits_reg;
        cnt_rel  = element_count_reg;
        ovf_rel  = overflowed_reg;
        if (release_hit)
        begin
            if (element_count_reg < MKD_CNT_W'(MKD_MAX_ELEMENTS))
            begin
                bits_rel = element_bits_reg
                         | (MKD_MAX_ELEMENTS'(dash) << element_count_reg);
                cnt_rel  = element_count_reg + MKD_CNT_W'(1);
            end
            else
                ovf_rel = 1'b1;
        end

        ch = ovf_rel ? 7'd0 : mkd_lookup(cnt_rel, bits_rel);

        rel_res.event_res     = dash ? EV_DASH : EV_DOT;
        rel_res.char_code     = 7'd0;
        rel_res.symbol_length = cnt_rel[2:0];
        rel_res.last          = !confirm_press;

        conf_res.event_res     = (ch != 7'd0) ? EV_CHAR : EV_UNKNOWN;
        conf_res.char_code     = ch;
        conf_res.symbol_length = cnt_rel[2:0];
        conf_res.last          = 1'b1;

        q_rec.two = release_hit && confirm_press;
        q_rec.r0  = release_hit ? rel_res : conf_res;
        q_rec.r1  = conf_res;
        q_push    = accept && (release_hit || confirm_press);

        if (clear_press)
        begin
            element_bits_next  = '0;
            element_count_next = '0;
            overflowed_next    = 1'b0;
        end
        else
        begin
            element_bits_next  = bits_rel;
            element_count_next = cnt_rel;
            overflowed_next    = ovf_rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_ticks_reg    <= MKD_DASH_TICKS_RST;
            key_held_reg      <= 1'b0;
            press_count_reg   <= '0;
            element_bits_reg  <= '0;
            element_count_reg <= '0;
            overflowed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                dash_ticks_reg <= cfg_wdata;
            if (accept)
            begin
                key_held_reg      <= key_held_next;
                press_count_reg   <= press_count_next;
                element_bits_reg  <= element_bits_next;
                element_count_reg <= element_count_next;
                overflowed_reg    <= overflowed_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        element_count_reg <= MKD_CNT_W'(MKD_MAX_ELEMENTS))
        else $error("element count beyond limit");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> element_count_reg == MKD_CNT_W'(MKD_MAX_ELEMENTS))
        else $error("overflow flagged on a string that is not full");

    a_bits_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (element_bits_reg >> element_count_reg) == '0)
        else $error("element bits set past the element count");
`endif

endmodule

/* src/mkd_queue.sv */
module mkd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  mkd_pkg::mkd_rec_t wr_rec,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output mkd_pkg::mkd_res_t head
);
    import mkd_pkg::*;

    mkd_rec_t              q_reg [MKD_QDEPTH];
    logic [MKD_QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [MKD_QPTR_W:0]   cnt_reg, cnt_next;
    logic                  half_reg;
    logic                  take, retire;
    mkd_rec_t              head_rec;

    always_comb
    begin
        head_rec = q_reg[rd_ptr_reg];
        full     = cnt_reg == (MKD_QPTR_W + 1)'(MKD_QDEPTH);
        empty    = cnt_reg == '0;
        head     = half_reg ? head_rec.r1 : head_rec.r0;
        take     = pop && !empty;
        // entry leaves once its final result is taken
        retire   = take && (half_reg || !head_rec.two);
        cnt_next = cnt_reg + (MKD_QPTR_W + 1)'(wr) - (MKD_QPTR_W + 1)'(retire);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + MKD_QPTR_W'(1);
            if (retire)
            begin
                rd_ptr_reg <= rd_ptr_reg + MKD_QPTR_W'(1);
                half_reg   <= 1'b0;
            end
            else if (take)
                half_reg <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (MKD_QPTR_W + 1)'(MKD_QDEPTH))
        else $error("queue count beyond depth");

    a_half_valid: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (!empty && head_rec.two))
        else $error("second result pending on a single-result entry");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> !full)
        else $error("queue written while full");
`endif

endmodule

/* src/morse_key_decoder_core.sv */
// channel   | handshake        | payload
// ----------+------------------+-----------------------------------------------
// input     | push / full      | key_level, clear_press, confirm_press
// result    | empty / pop      | event_res, char_code, symbol_length, last
// config    | cfg_we           | cfg_wdata (dash_ticks)
//
// one sample is taken per clock while full is low; key timing and decode
// finish in that cycle and the one or two results land in a four-entry queue
// results drain at one per cycle, so two-result samples can fill the queue
// full rises only while four samples wait; pop and push are independent
// rst_n clears key timing, the string and the queue; dash_ticks returns to 750
module morse_key_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           key_level,
    input  logic                           clear_press,
    input  logic                           confirm_press,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     event_res,
    output logic [6:0]                     char_code,
    output logic [2:0]                     symbol_length,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [mkd_pkg::MKD_TICK_W-1:0] cfg_wdata
);
    import mkd_pkg::*;

    logic     accept;
    logic     q_push;
    mkd_rec_t q_rec;
    mkd_res_t head;

    assign accept = push && !full;

    mkd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .key_level     (key_level),
        .clear_press   (clear_press),
        .confirm_press (confirm_press),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_push        (q_push),
        .q_rec         (q_rec)
    );

    mkd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wr_rec (q_rec),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .head   (head)
    );

    assign event_res     = head.event_res;
    assign char_code     = head.char_code;
    assign symbol_length = head.symbol_length;
    assign last          = head.last;

endmodule

/* tb/morse_shadow_pkg.sv */
package morse_shadow_pkg;

    import mkd_pkg::*;

    // tracks the key timing and the held element string, and keeps the
    // results that every accepted request should produce, oldest first
    class morse_shadow;
        logic [MKD_TICK_W-1:0]       dash_ticks;
        bit                          key_held;
        logic [MKD_TICK_W-1:0]       press_count;
        logic [MKD_MAX_ELEMENTS-1:0] element_bits;
        int unsigned                 element_count;
        bit                          overflowed;
        string                       code_pattern[27];
        string                       code_letter;
        mkd_res_t                    due_results[$];
        int unsigned                 mismatch_count;

        function new();
            dash_ticks     = MKD_DASH_TICKS_RST;
            key_held       = 1'b0;
            press_count    = '0;
            element_bits   = '0;
            element_count  = 0;
            overflowed     = 1'b0;
            mismatch_count = 0;
            code_pattern   = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                               ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                               "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
                               "-----"};
            code_letter    = "ABCDEFGHIJKLMNOPQRSTUVWXYZ ";
        endfunction

        // ascii of the held string, 0 when no pattern matches
        function logic [6:0] held_char();
            logic [MKD_MAX_ELEMENTS-1:0] bits;
            logic [6:0]                  ch;
            ch = 7'd0;
            for (int e = 0; e < 27; e++)
            begin
                bits = '0;
                for (int i = 0; i < code_pattern[e].len(); i++)
                    if (code_pattern[e][i] == "-")
                        bits[i] = 1'b1;
                if (code_pattern[e].len() == element_count && bits == element_bits)
                    ch = 7'(code_letter[e]);
            end
            return ch;
        endfunction

        function void take_sample(bit key, bit clr, bit conf);
            mkd_res_t   out[2];
            int         n;
            bit         dash;
            logic [6:0] ch;
            n = 0;
            if (key)
            begin
                if (!key_held)
                begin
                    key_held    = 1'b1;
                    press_count = MKD_TICK_W'(1);
                end
                else if (press_count != MKD_PRESS_SAT)
                begin
                    press_count = press_count + MKD_TICK_W'(1);
                end
            end
            else if (key_held)
            begin
                dash = press_count > dash_ticks;
                if (element_count < MKD_MAX_ELEMENTS)
                begin
                    if (dash)
                        element_bits[element_count] = 1'b1;
                    element_count++;
                end
                else
                begin
                    // string full: the element is lost
                    overflowed = 1'b1;
                end
                key_held    = 1'b0;
                press_count = '0;
                out[n] = {dash ? EV_DASH : EV_DOT, 7'd0, 3'(element_count), 1'b0};
                n++;
            end
            // decode sees the element added by this sample's release
            if (conf)
            begin
                ch = overflowed ? 7'd0 : held_char();
                out[n] = {(ch != 7'd0) ? EV_CHAR : EV_UNKNOWN, ch, 3'(element_count), 1'b0};
                n++;
            end
            if (clr)
            begin
                element_bits  = '0;
                element_count = 0;
                overflowed    = 1'b0;
            end
            for (int k = 0; k < n; k++)
            begin
                out[k].last = (k == n - 1);
                due_results = {due_results, out[k]};
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatch_count++;
            end
        endfunction

        function void match_result(mkd_res_t got);
            mkd_res_t want;
            if (due_results.size() == 0)
            begin
                $error({"result with no request pending: ",
                        "event_res %0d char_code %0d symbol_length %0d last %0d"},
                       got.event_res, got.char_code, got.symbol_length, got.last);
                mismatch_count++;
                return;
            end
            want = due_results.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("char_code", want.char_code, got.char_code);
            compare_field("symbol_length", want.symbol_length, got.symbol_length);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

endpackage

/* tb/testbench.sv */
module testbench;

    import mkd_pkg::*;
    import morse_shadow_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  key_level;
    logic                  clear_press;
    logic                  confirm_press;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            event_res;
    logic [6:0]            char_code;
    logic [2:0]            symbol_length;
    logic                  last;
    logic                  cfg_we;
    logic [MKD_TICK_W-1:0] cfg_wdata;

    int unsigned send_idle    = 0;
    int unsigned recv_idle    = 0;
    int unsigned ticks_sent   = 0;
    int unsigned stall_cycles = 0;
    morse_shadow shadow;

    morse_key_decoder_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .key_level     (key_level),
        .clear_press   (clear_press),
        .confirm_press (confirm_press),
        .empty         (empty),
        .pop           (pop),
        .event_res     (event_res),
        .char_code     (char_code),
        .symbol_length (symbol_length),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        pop <= ($urandom_range(0, 99) >= recv_idle);

    // outputs and handshakes are stable at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
            shadow.match_result({event_res, char_code, symbol_length, last});
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // returns at the edge that takes the request
    task automatic send_tick(input bit key, input bit clr, input bit conf);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        key_level     <= key;
        clear_press   <= clr;
        confirm_press <= conf;
        @(negedge clk);
        while (full)
            @(negedge clk);
        shadow.take_sample(key, clr, conf);
        ticks_sent++;
        @(posedge clk);
    endtask

    task automatic press_key(input int unsigned ticks, input bit conf, input bit clr);
        repeat (ticks) send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, clr, conf);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (shadow.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // release the key first so no press spans the threshold change
    task automatic set_threshold(input logic [MKD_TICK_W-1:0] value);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow.dash_ticks = value;
    endtask

    // one symbol keyed element by element, then confirm and usually clear
    task automatic send_letter();
        int unsigned n_elem;
        int unsigned len;
        bit          merge;
        n_elem = ($urandom_range(0, 14) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
        merge  = 1'($urandom_range(0, 1));
        for (int i = 0; i < n_elem; i++)
        begin
            if ($urandom_range(0, 1))
                len = shadow.dash_ticks + $urandom_range(1, 3);
            else
                len = $urandom_range(1, (shadow.dash_ticks == 0) ? 1 : shadow.dash_ticks);
            for (int j = 0; j < len; j++)
                send_tick(1'b1, $urandom_range(0, 39) == 0, 1'b0);
            if (merge && i == n_elem - 1)
                send_tick(1'b0, $urandom_range(0, 3) == 0, 1'b1);
            else
                repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, 1'b0);
        end
        if (!merge || n_elem == 0)
            send_tick(1'b0, $urandom_range(0, 3) == 0, 1'b1);
        if ($urandom_range(0, 3) != 0)
            send_tick(1'b0, 1'b1, 1'b0);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned start;
        start = ticks_sent;
        while (ticks_sent - start < count)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
            else
                send_letter();
        end
    endtask

    initial
    begin
        shadow        = new();
        rst_n         = 1'b0;
        push          = 1'b0;
        key_level     = 1'b0;
        clear_press   = 1'b0;
        confirm_press = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 11;
        recv_idle = 60;
        send_tick(1'b0, 1'b0, 1'b1);   // empty string has no code
        press_key(1, 1'b1, 1'b0);      // short press at the reset threshold
        send_tick(1'b0, 1'b1, 1'b1);   // decode, then clear in the same tick
        set_threshold(16'd1);
        press_key(1, 1'b0, 1'b0);
        press_key(2, 1'b1, 1'b0);      // release and decode in one tick
        send_tick(1'b0, 1'b1, 1'b0);
        repeat (5) press_key(2, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);   // five dashes give a space
        press_key(1, 1'b0, 1'b0);      // string full, element dropped
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        repeat (4) press_key(2, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);   // four dashes are not a letter
        send_tick(1'b1, 1'b1, 1'b0);   // clear while the key is down
        send_tick(1'b0, 1'b1, 1'b1);   // release, decode and clear together

        set_threshold(16'd3);
        run_random(420);

        send_idle = 60;
        recv_idle = 11;
        set_threshold(16'd0);
        run_random(200);
        set_threshold(16'd2);
        run_random(220);

        send_idle = 0;
        recv_idle = 0;
        set_threshold(16'd1);
        run_random(420);

        // widest threshold: a short press stays a dot
        set_threshold(16'hFFFF);
        send_tick(1'b0, 1'b1, 1'b0);
        press_key(3, 1'b1, 1'b1);
        set_threshold(16'hFFFE);
        press_key(3, 1'b1, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        if (shadow.mismatch_count == 0 && shadow.due_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
src/mkd_pkg.sv
src/mkd_front.sv
src/mkd_queue.sv
src/morse_key_decoder_core.sv
tb/morse_shadow_pkg.sv
tb/testbench.sv
